FILE: rtl/core/aasd_pkg.sv
// ----------------------------------------------------------------------------
// aasd_pkg
// Shared widths, constants and types of the audio activity span detector.
// ----------------------------------------------------------------------------
package aasd_pkg;

    localparam int INDEX_BITS_DEF = 24;
    localparam int SAMPLE_W       = 16;
    localparam int OUT_W          = 25;
    localparam int THR_W          = 31;
    localparam int THR50_W        = THR_W + 6;
    localparam int TERM_W         = 21;   // signed working width of the terms
    localparam int A_W            = 18;
    localparam int B_W            = 18;
    localparam int C_W            = 19;
    localparam int AB_W           = A_W + B_W;
    localparam int AB_HALF        = AB_W / 2;
    localparam int PART_W         = C_W + AB_HALF;
    localparam int PROD_W         = 56;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [THR50_W-1:0] THR50_RESET = THR50_W'(4096 * 50);

    // magnitudes of the three factors of the activity measure
    typedef struct packed {
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
        logic [C_W-1:0] c;
    } aasd_terms_t;

    localparam int TERMS_W = $bits(aasd_terms_t);

endpackage

FILE: rtl/core/aasd_front.sv
// ----------------------------------------------------------------------------
// aasd_front
// Accepts samples, keeps the five-sample history and the run index, and forms
// the magnitudes of the three factors of the activity measure.
// ----------------------------------------------------------------------------
module aasd_front
    import aasd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_last_sample,
    output logic                       q_valid,
    input  logic                       q_ready,
    output aasd_terms_t                q_terms,
    output logic [INDEX_BITS-1:0]      q_index,
    output logic                       q_last
);

    logic [SAMPLE_W-1:0]   hist_reg [5];
    logic [SAMPLE_W-1:0]   eff [5];
    logic [INDEX_BITS-1:0] count_reg;
    logic [INDEX_BITS-1:0] count_next;
    logic                  accept;

    logic signed [TERM_W-1:0] e [5];
    logic signed [TERM_W-1:0] cur;
    logic signed [TERM_W-1:0] sum4;
    logic signed [TERM_W-1:0] ta;
    logic signed [TERM_W-1:0] tb;
    logic signed [TERM_W-1:0] tc;
    logic [TERM_W-1:0]        ma;
    logic [TERM_W-1:0]        mb;
    logic [TERM_W-1:0]        mc;

    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign accept  = s_valid && q_ready;

    // first sample of a run preloads the whole history
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            eff[i] = (count_reg == '0) ? s_sample : hist_reg[i];
            e[i]   = {{(TERM_W-SAMPLE_W){eff[i][SAMPLE_W-1]}}, eff[i]};
        end
        cur  = {{(TERM_W-SAMPLE_W){s_sample[SAMPLE_W-1]}}, s_sample};
        sum4 = e[0] + e[1] + e[2] + e[3];
        ta   = (e[4] <<< 1) + (cur <<< 1) - sum4;
        tb   = (e[4] <<< 2) - sum4;
        tc   = (cur <<< 2) + cur - sum4 - e[4];
        ma   = ta[TERM_W-1] ? TERM_W'(-ta) : TERM_W'(ta);
        mb   = tb[TERM_W-1] ? TERM_W'(-tb) : TERM_W'(tb);
        mc   = tc[TERM_W-1] ? TERM_W'(-tc) : TERM_W'(tc);
    end

    assign q_terms.a = ma[A_W-1:0];
    assign q_terms.b = mb[B_W-1:0];
    assign q_terms.c = mc[C_W-1:0];
    assign q_index   = count_reg;
    assign q_last    = s_last_sample;

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (s_last_sample) begin
                count_next = '0;
            end else if (count_reg != '1) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < 4; i++) begin
                hist_reg[i] <= eff[i+1];
            end
            hist_reg[4] <= s_sample;
        end
    end

endmodule

FILE: rtl/core/aasd_queue.sv
// ----------------------------------------------------------------------------
// aasd_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module aasd_queue
    import aasd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/core/aasd_back.sv
// ----------------------------------------------------------------------------
// aasd_back
// Multiplies out the activity measure, compares it with the threshold and
// tracks the active span; one result per run in the output register.
// ----------------------------------------------------------------------------
module aasd_back
    import aasd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [THR50_W-1:0]       thr50,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  aasd_terms_t              q_terms,
    input  logic [INDEX_BITS-1:0]    q_index,
    input  logic                     q_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_start_index,
    output logic signed [OUT_W-1:0]  m_end_index,
    output logic                     m_found
);

    logic                  en;

    // stage 1: a*b
    logic                  s1_v_reg;
    logic [AB_W-1:0]       s1_ab_reg;
    logic [C_W-1:0]        s1_c_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    logic                  s1_last_reg;

    // stage 2: two partial products against c
    logic                  s2_v_reg;
    logic [PART_W-1:0]     s2_lo_reg;
    logic [PART_W-1:0]     s2_hi_reg;
    logic [INDEX_BITS-1:0] s2_idx_reg;
    logic                  s2_last_reg;

    // span tracking
    logic                  any_reg;
    logic [INDEX_BITS-1:0] first_reg;
    logic [INDEX_BITS-1:0] lastidx_reg;

    logic                  m_valid_reg;
    logic [OUT_W-1:0]      start_reg;
    logic [OUT_W-1:0]      end_reg;
    logic                  found_reg;

    logic [PROD_W-1:0]     prod;
    logic                  active;
    logic                  any_eff;
    logic [INDEX_BITS-1:0] first_eff;
    logic [INDEX_BITS-1:0] last_eff;
    logic [INDEX_BITS+OUT_W-1:0] first_wide;
    logic [INDEX_BITS+OUT_W-1:0] last_wide;

    assign en      = !m_valid_reg || m_ready;
    assign q_ready = en;

    assign prod    = (PROD_W'(s2_hi_reg) << AB_HALF) + PROD_W'(s2_lo_reg);
    assign active  = prod > PROD_W'(thr50);
    assign any_eff   = any_reg || active;
    assign first_eff = any_reg ? first_reg : s2_idx_reg;
    assign last_eff  = active ? s2_idx_reg : lastidx_reg;
    // index widened then cut to the output width
    assign first_wide = {{OUT_W{1'b0}}, first_eff};
    assign last_wide  = {{OUT_W{1'b0}}, last_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg    <= q_valid;
            s2_v_reg    <= s1_v_reg;
            m_valid_reg <= s2_v_reg && s2_last_reg;
            if (s2_v_reg) begin
                any_reg <= s2_last_reg ? 1'b0 : any_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ab_reg   <= AB_W'(q_terms.a) * AB_W'(q_terms.b);
            s1_c_reg    <= q_terms.c;
            s1_idx_reg  <= q_index;
            s1_last_reg <= q_last;

            s2_lo_reg   <= PART_W'(s1_c_reg) * PART_W'(s1_ab_reg[AB_HALF-1:0]);
            s2_hi_reg   <= PART_W'(s1_c_reg) * PART_W'(s1_ab_reg[AB_W-1:AB_HALF]);
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;

            if (s2_v_reg) begin
                first_reg   <= first_eff;
                lastidx_reg <= last_eff;
            end
            if (s2_v_reg && s2_last_reg) begin
                found_reg <= any_eff;
                start_reg <= any_eff ? first_wide[OUT_W-1:0] : '1;
                end_reg   <= any_eff ? last_wide[OUT_W-1:0] : '1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_start_index = start_reg;
    assign m_end_index   = end_reg;
    assign m_found       = found_reg;

endmodule

FILE: rtl/core/audio_activity_span_detector.sv
// ----------------------------------------------------------------------------
// audio_activity_span_detector
// Finds the first and last sample of a run whose activity measure exceeds 50
// times the programmed threshold.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle. The front part keeps the history and the
// run index and forms the three factors of the measure; a four-entry queue
// hands them to a three-stage back end (a*b, two partial products, sum and
// compare against 50 x threshold), so a sustained rate of one sample per
// clock holds while results are taken. A run's result passes the queue, the
// back-end stages and the output register after its last sample is accepted,
// later only while an earlier result still waits unread in the output
// register; while it waits the back end holds and the queue fills, after
// which s_ready drops. The threshold should be written only with the block
// idle; it takes effect from the next cycle. No clearing pass after reset.
module audio_activity_span_detector
    import aasd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [THR_W-1:0]           cfg_activity_threshold,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_last_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_W-1:0]    m_start_index,
    output logic signed [OUT_W-1:0]    m_end_index,
    output logic                       m_found
);

    localparam int ENTRY_W = 1 + INDEX_BITS + TERMS_W;

    logic [THR50_W-1:0]    thr50_reg;
    logic [THR50_W-1:0]    thr50_next;
    logic [THR50_W-1:0]    thr_ext;

    logic                  fq_valid;
    logic                  fq_ready;
    aasd_terms_t           fq_terms;
    logic [INDEX_BITS-1:0] fq_index;
    logic                  fq_last;
    logic                  qb_valid;
    logic                  qb_ready;
    logic [ENTRY_W-1:0]    qb_data;
    aasd_terms_t           qb_terms;

    // threshold kept pre-scaled by 50 = 32 + 16 + 2
    assign cfg_ready  = 1'b1;
    assign thr_ext    = THR50_W'(cfg_activity_threshold);
    assign thr50_next = (thr_ext << 5) + (thr_ext << 4) + (thr_ext << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr50_reg <= THR50_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr50_reg <= thr50_next;
        end
    end

    aasd_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_terms       (fq_terms),
        .q_index       (fq_index),
        .q_last        (fq_last)
    );

    aasd_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_last, fq_index, fq_terms}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    assign qb_terms = qb_data[TERMS_W-1:0];

    aasd_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .thr50         (thr50_reg),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_terms       (qb_terms),
        .q_index       (qb_data[TERMS_W+INDEX_BITS-1:TERMS_W]),
        .q_last        (qb_data[ENTRY_W-1]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_start_index (m_start_index),
        .m_end_index   (m_end_index),
        .m_found       (m_found)
    );

    // no active sample: both indices read -1
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_start_index == '1) && (m_end_index == '1))
        else $error("empty span without -1 indices");

    // narrow index: a found span never carries a negative index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found && (INDEX_BITS < OUT_W)
        |-> !m_start_index[OUT_W-1] && !m_end_index[OUT_W-1])
        else $error("found span with negative index");

    // threshold write lands scaled by 50
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready
        |=> thr50_reg == THR50_W'(50) * THR50_W'($past(cfg_activity_threshold)))
        else $error("threshold scaling wrong");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the audio activity span detector. Runs of samples are sent
// over the request channel while both sides idle at random. A predictor of
// its own follows each accepted sample and queues the span that each run
// must report; every result is checked field by field against that queue.
// ----------------------------------------------------------------------------
module tb;
    import aasd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;
    localparam longint MAX_INDEX = (64'd1 << INDEX_BITS_DEF) - 1;
    localparam logic [THR_W-1:0] THR_MAX = THR_W'(1 << 30);

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       is_last;
    } sample_req_t;

    typedef struct {
        logic signed [OUT_W-1:0] start_idx;
        logic signed [OUT_W-1:0] end_idx;
        logic                    found;
    } span_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [THR_W-1:0]           cfg_activity_threshold;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       s_last_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [OUT_W-1:0]    m_start_index;
    logic signed [OUT_W-1:0]    m_end_index;
    logic                       m_found;

    // stimulus and bookkeeping
    sample_req_t sample_q[$];
    span_t       span_q[$];
    int          samples_in_flight = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          idle_en = 1'b1;
    bit          in_taken = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          sink_hold = 0;

    // predictor state
    logic signed [SAMPLE_W-1:0] hist[5];
    longint                     run_index;
    longint                     first_idx;
    longint                     last_idx;
    logic [THR_W-1:0]           thr_q;

    audio_activity_span_detector u_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_activity_threshold (cfg_activity_threshold),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_sample               (s_sample),
        .s_last_sample          (s_last_sample),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_start_index          (m_start_index),
        .m_end_index            (m_end_index),
        .m_found                (m_found)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    task automatic reset_span_model();
        foreach (hist[i]) hist[i] = '0;
        run_index = 0;
        first_idx = -1;
        last_idx  = -2;
        thr_q     = THR_W'(4096);
    endtask

    task automatic advance_span(input logic signed [SAMPLE_W-1:0] smp, input logic is_last);
        longint            s4, s5, ta, tb_, tc, fa, fb, fc, e;
        longint unsigned   prod;
        span_t             sp;
        // a fresh run starts with a flat history, so its first measure is zero
        if (run_index == 0)
            foreach (hist[i]) hist[i] = smp;
        s4  = longint'(hist[0]) + longint'(hist[1]) + longint'(hist[2]) + longint'(hist[3]);
        s5  = s4 + longint'(hist[4]);
        ta  = 2 * longint'(hist[4]) + 2 * longint'(smp) - s4;
        tb_ = 5 * longint'(hist[4]) - s5;
        tc  = 5 * longint'(smp) - s5;
        fa  = (ta < 0) ? -ta : ta;
        fb  = (tb_ < 0) ? -tb_ : tb_;
        fc  = (tc < 0) ? -tc : tc;
        prod = fa * fb * fc;
        for (int i = 0; i < 4; i++) hist[i] = hist[i + 1];
        hist[4] = smp;
        if (prod > 64'(thr_q) * 64'd50) begin
            if (first_idx < 0) first_idx = run_index;
            if (last_idx < run_index) last_idx = run_index;
        end
        if (run_index < MAX_INDEX) run_index++;
        if (is_last) begin
            e = (last_idx < -1) ? -64'sd1 : last_idx;
            sp.start_idx = first_idx[OUT_W-1:0];
            sp.end_idx   = e[OUT_W-1:0];
            sp.found     = (last_idx >= first_idx);
            span_q.push_back(sp);
            run_index = 0;
            first_idx = -1;
            last_idx  = -2;
        end
    endtask

    // accepted requests and register writes feed the predictor
    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            advance_span(s_sample, s_last_sample);
            samples_in_flight--;
        end
        if (aresetn && cfg_valid && cfg_ready)
            thr_q = cfg_activity_threshold;
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        span_t sp;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (span_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: start %0d end %0d found %0b",
                             m_start_index, m_end_index, m_found);
            end else begin
                sp = span_q.pop_front();
                if (m_start_index !== sp.start_idx || m_end_index !== sp.end_idx
                        || m_found !== sp.found) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: start %0d/%0d end %0d/%0d found %0b/%0b (exp/got)",
                                 sp.start_idx, m_start_index, sp.end_idx, m_end_index,
                                 sp.found, m_found);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // request driver and result sink, both at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        sample_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (sample_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 7);
                s_valid <= 1'b0;
            end else begin
                req = sample_q.pop_front();
                s_valid       <= 1'b1;
                s_sample      <= req.smp;
                s_last_sample <= req.is_last;
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic is_last);
        sample_req_t req;
        req.smp     = smp;
        req.is_last = is_last;
        while (sample_q.size() >= 2) @(posedge aclk);
        sample_q.push_back(req);
        samples_in_flight++;
        items_sent++;
    endtask

    // every request accepted, every span reported, pipeline settled
    task automatic wait_idle();
        while (samples_in_flight != 0 || span_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(negedge aclk);
        cfg_valid              <= 1'b1;
        cfg_activity_threshold <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned run_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
    endfunction

    // loud and quiet stretches: the level sets how many low bits are live
    task automatic send_random_run(input int unsigned len);
        logic [SAMPLE_W-1:0] raw;
        int unsigned         level;
        level = $urandom_range(0, 16);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0) level = $urandom_range(0, 16);
            raw = SAMPLE_W'($urandom);
            case ($urandom_range(0, 19))
                0:       raw = 16'h8000;
                1:       raw = 16'h7FFF;
                default: raw = SAMPLE_W'($signed(raw) >>> (16 - level));
            endcase
            send_sample(raw, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // one-sample runs never go active
    task automatic test_lone_sample();
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sd32768, 1'b1);
        wait_idle();
    endtask

    task automatic test_extreme_swing();
        write_threshold('0);
        for (int i = 0; i < 5; i++)
            send_sample((i % 2) ? 16'sh7FFF : -16'sd32768, i == 4);
        wait_idle();
        write_threshold(THR_MAX);
        for (int i = 0; i < 5; i++)
            send_sample((i % 2) ? -16'sd32768 : 16'sh7FFF, i == 4);
        wait_idle();
    endtask

    // flat signal gives a zero measure, which does not beat a zero threshold
    task automatic test_flat_run();
        write_threshold('0);
        for (int i = 0; i < 4; i++) send_sample(16'sd1234, i == 3);
        wait_idle();
    endtask

    task automatic test_burst_span();
        logic signed [SAMPLE_W-1:0] burst[8] = '{0, 0, 0, 800, -900, 700, 0, 0};
        write_threshold(THR_W'(4096));
        foreach (burst[i]) send_sample(burst[i], i == 7);
        wait_idle();
    endtask

    task automatic test_random_runs();
        logic [THR_W-1:0] thr;
        while (items_sent < 680 || results_seen < 40) begin
            case ($urandom_range(0, 5))
                0:       thr = '0;
                1:       thr = THR_MAX;
                2:       thr = THR_W'(4096);
                default: thr = THR_W'($urandom_range(0, 1 << $urandom_range(0, 30)));
            endcase
            write_threshold(thr);
            repeat ($urandom_range(1, 6)) send_random_run(run_length());
            wait_idle();
        end
    endtask

    // sink stalls for a long stretch; short runs fill the result path
    task automatic test_output_backpressure();
        sink_hold = 120;
        repeat (30) send_random_run($urandom_range(1, 3));
        wait_idle();
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        write_threshold(THR_W'($urandom_range(0, 1 << 20)));
        while (items_sent < 950) send_random_run(run_length());
        wait_idle();
    endtask

    initial begin
        reset_span_model();
        aresetn                = 1'b0;
        cfg_valid              = 1'b0;
        cfg_activity_threshold = '0;
        s_valid                = 1'b0;
        s_sample               = '0;
        s_last_sample          = 1'b0;
        m_ready                = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_lone_sample();
        test_extreme_swing();
        test_flat_run();
        test_burst_span();
        test_random_runs();
        test_output_backpressure();
        test_steady_stream();

        if (fail_count == 0 && span_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/aasd_pkg.sv
rtl/core/aasd_front.sv
rtl/core/aasd_queue.sv
rtl/core/aasd_back.sv
rtl/core/audio_activity_span_detector.sv
dv/tb.sv
